@@ rtl/core/fpf_pkg.sv @@
// shared types, constants and field encoding functions of the packet framer
package fpf_pkg;

    localparam int PktLen   = 45;
    localparam int BodyLen  = PktLen - 1;
    localparam int CntW     = $clog2(PktLen);
    localparam int ChkFirst = 16;

    localparam logic [CntW-1:0] LastIdx = CntW'(PktLen - 1);
    localparam logic [CntW-1:0] ChkIdx  = CntW'(ChkFirst);

    localparam logic [7:0] FdType   = 8'hD1;
    localparam logic [7:0] CsumBase = 8'h40;

    localparam logic [31:0] Magic = {8'h31, 8'h51, 8'h54, 8'h53};

    localparam logic [32:0] S24MaxMag = 33'd8388607;
    localparam logic [32:0] S24MinMag = 33'd8388608;

    typedef struct packed {
        logic [31:0]        frame_number;
        logic [63:0]        stamp_ms;
        logic [7:0]         camera_number;
        logic signed [31:0] pan_angle;
        logic signed [31:0] tilt_angle;
        logic signed [31:0] roll_angle;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] zoom_value;
        logic signed [31:0] focus_value;
    } sample_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } result_t;

    typedef logic [BodyLen-1:0][7:0] body_t;

    // halve, rounding half away from zero, then saturate to signed 24
    function automatic logic [23:0] half_sat24(input logic signed [31:0] v);
        logic        neg;
        logic [32:0] mag;
        logic [32:0] half;
        logic [23:0] res;
        neg  = v[31];
        mag  = neg ? (33'd0 - {v[31], v}) : {1'b0, v};
        half = (mag + 33'd1) >> 1;
        if (!neg && half > S24MaxMag)
        begin
            res = 24'h7FFFFF;
        end
        else if (neg && half > S24MinMag)
        begin
            res = 24'h800000;
        end
        else if (neg)
        begin
            res = 24'(33'd0 - half);
        end
        else
        begin
            res = half[23:0];
        end
        return res;
    endfunction

    function automatic logic [23:0] lens24(input logic signed [31:0] v);
        return v[31] ? 24'd0 : v[23:0];
    endfunction

endpackage

@@ rtl/core/fpf_encode.sv @@
// builds packet bytes 0 to 43 from one registered sample
module fpf_encode (
    input  fpf_pkg::sample_t sample,
    output fpf_pkg::body_t   body
);

    logic [7:0][23:0] f24;

    always_comb
    begin
        f24[0] = fpf_pkg::half_sat24(sample.pan_angle);
        f24[1] = fpf_pkg::half_sat24(sample.tilt_angle);
        f24[2] = fpf_pkg::half_sat24(sample.roll_angle);
        f24[3] = fpf_pkg::half_sat24(sample.pos_x);
        f24[4] = fpf_pkg::half_sat24(sample.pos_z);
        f24[5] = fpf_pkg::half_sat24(sample.pos_y);
        f24[6] = fpf_pkg::lens24(sample.zoom_value);
        f24[7] = fpf_pkg::lens24(sample.focus_value);
    end

    always_comb
    begin
        body = '0;
        for (int i = 0; i < 4; i++)
        begin
            body[i]     = fpf_pkg::Magic[8*i +: 8];
            body[4 + i] = sample.frame_number[8*i +: 8];
        end
        for (int i = 0; i < 8; i++)
        begin
            body[8 + i] = sample.stamp_ms[8*i +: 8];
        end
        body[fpf_pkg::ChkFirst]     = fpf_pkg::FdType;
        body[fpf_pkg::ChkFirst + 1] = sample.camera_number;
        // 24-bit fields go out big-endian
        for (int k = 0; k < 8; k++)
        begin
            body[fpf_pkg::ChkFirst + 2 + 3*k]     = f24[k][23:16];
            body[fpf_pkg::ChkFirst + 2 + 3*k + 1] = f24[k][15:8];
            body[fpf_pkg::ChkFirst + 2 + 3*k + 2] = f24[k][7:0];
        end
    end

endmodule

@@ rtl/core/fpf_serializer.sv @@
// shifts packet bytes out one per cycle and appends the running checksum
module fpf_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fpf_pkg::body_t   body,
    output logic             take,
    output logic             strobe,
    output fpf_pkg::result_t result
);

    logic                     active_reg, active_next;
    logic [fpf_pkg::CntW-1:0] cnt_reg, cnt_next;
    fpf_pkg::body_t           buf_reg, buf_next;
    logic [7:0]               sum_reg, sum_next;
    logic                     strobe_reg, strobe_next;
    fpf_pkg::result_t         res_reg, res_next;
    logic                     at_last;

    assign at_last = (cnt_reg == fpf_pkg::LastIdx);
    assign take    = !active_reg || at_last;

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        buf_next    = buf_reg;
        sum_next    = sum_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        if (active_reg)
        begin
            strobe_next          = 1'b1;
            res_next.last_byte   = at_last;
            res_next.packet_byte = at_last ? (fpf_pkg::CsumBase - sum_reg) : buf_reg[0];
            if (!at_last && cnt_reg >= fpf_pkg::ChkIdx)
            begin
                sum_next = sum_reg + buf_reg[0];
            end
            buf_next = buf_reg >> 8;
            cnt_next = cnt_reg + 1'b1;
            if (at_last)
            begin
                active_next = 1'b0;
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            buf_next    = body;
            sum_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        sum_reg <= sum_next;
        res_reg <= res_next;
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.last_byte && strobe_reg |-> strobe_reg && at_last == 1'b0 || active_reg)
        else $error("last byte without following state");

    a_bytes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !res_reg.last_byte |-> active_reg)
        else $error("packet interrupted before last byte");

    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ##2 (strobe_reg && !res_reg.last_byte))
        else $error("first byte missing after load");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> cnt_reg <= fpf_pkg::LastIdx)
        else $error("byte counter out of range");

endmodule

@@ rtl/core/freed_packet_framer_top.sv @@
// top level of the tracking packet framer: request register, encoder and serializer
//
//  port    dir  width   handshake
//  sample  in   360     start high and busy low at the clock edge
//  result  out  9       strobe high with each byte, no back pressure
//
// each request yields 45 bytes on consecutive cycles; with the serializer idle, an accepted
// request passes pend_reg, then active_reg and buf_reg, then strobe_reg and res_reg
// the serializer sets the rate: it loads a request only while idle or while it forms the checksum
// a request is held in one buffer register while the previous packet drains,
// so packets follow each other with no gap
// busy is high only while that buffer holds a request not yet taken
// reset clears the buffer and serializer control; no result is pending after it
module freed_packet_framer_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fpf_pkg::sample_t sample,
    output logic             strobe,
    output fpf_pkg::result_t result
);

    logic             pend_reg, pend_next;
    fpf_pkg::sample_t sample_reg;
    fpf_pkg::body_t   body;
    logic             take;
    logic             load;
    logic             accept;

    assign busy   = pend_reg;
    assign accept = start && !pend_reg;
    assign load   = pend_reg && take;

    always_comb
    begin
        pend_next = pend_reg;
        if (load)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
    end

    fpf_encode u_encode (
        .sample (sample_reg),
        .body   (body)
    );

    fpf_serializer u_serializer (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .body   (body),
        .take   (take),
        .strobe (strobe),
        .result (result)
    );

endmodule
